@@ rtl/i2c_register_table_writer_unit_defines.svh @@
// assertion macros shared by the register table writer rtl
`ifndef I2C_REGISTER_TABLE_WRITER_UNIT_DEFINES_SVH
`define I2C_REGISTER_TABLE_WRITER_UNIT_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define I2CRTW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define I2CRTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/i2crtw_pkg.sv @@
// shared types, constants and sequencer microcode for the register table writer
`timescale 1ns / 1ps
`default_nettype none

package i2crtw_pkg;

   localparam int TableDepth    = 256;
   localparam int IndexWidth    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CountWidth    = $clog2(TableDepth + 1);
   localparam int ByteWidth     = 8;
   localparam int EntryWidth    = 2 * ByteWidth;
   localparam int DevAddrWidth  = 7;
   localparam int BitCountWidth = $clog2(ByteWidth);
   localparam int LastBit       = ByteWidth - 1;
   localparam logic [DevAddrWidth-1:0] DevAddrReset = 7'h60;
   localparam logic [ByteWidth-1:0]    MsbMask      = 8'h80;

   typedef enum logic [1:0] {
      OpAppend,
      OpStart,
      OpTick,
      OpNop
   } op_type;

   typedef enum logic [3:0] {
      PhIdle,
      PhStartSda,
      PhStartScl,
      PhStartGap,
      PhBitHigh,
      PhBitLow,
      PhAckRelease,
      PhAckHigh,
      PhAckRead,
      PhStopScl,
      PhStopSda,
      PhStopGap
   } phase_type;

   typedef enum logic [1:0] {
      ByteDevice,
      ByteRegister,
      ByteValue
   } byte_sel_type;

   typedef enum logic [1:0] {
      PinKeep,
      PinLow,
      PinHigh
   } pin_op_type;

   typedef enum logic [1:0] {
      CondNone,
      CondBitMore,
      CondAckMore,
      CondEntryMore
   } cond_type;

   typedef struct packed {
      pin_op_type scl_op;
      pin_op_type sda_op;
      logic       load_first;
      cond_type   cond;
      phase_type  next_step;
      phase_type  jump_step;
   } ucode_type;

   // control store, one word per bus phase
   function automatic ucode_type ucode_rom(input phase_type step);
      ucode_type uc;
      unique case (step)
         PhStartSda:   uc = '{PinKeep, PinLow,  1'b0, CondNone,      PhStartScl,   PhIdle};
         PhStartScl:   uc = '{PinLow,  PinKeep, 1'b0, CondNone,      PhStartGap,   PhIdle};
         PhStartGap:   uc = '{PinKeep, PinKeep, 1'b1, CondNone,      PhBitHigh,    PhIdle};
         PhBitHigh:    uc = '{PinHigh, PinKeep, 1'b0, CondNone,      PhBitLow,     PhIdle};
         PhBitLow:     uc = '{PinLow,  PinKeep, 1'b0, CondBitMore,   PhAckRelease, PhBitHigh};
         PhAckRelease: uc = '{PinKeep, PinHigh, 1'b0, CondNone,      PhAckHigh,    PhIdle};
         PhAckHigh:    uc = '{PinHigh, PinKeep, 1'b0, CondNone,      PhAckRead,    PhIdle};
         PhAckRead:    uc = '{PinLow,  PinLow,  1'b0, CondAckMore,   PhStopScl,    PhBitHigh};
         PhStopScl:    uc = '{PinHigh, PinKeep, 1'b0, CondNone,      PhStopSda,    PhIdle};
         PhStopSda:    uc = '{PinKeep, PinHigh, 1'b0, CondNone,      PhStopGap,    PhIdle};
         PhStopGap:    uc = '{PinKeep, PinKeep, 1'b0, CondEntryMore, PhIdle,       PhStartSda};
         default:      uc = '{PinKeep, PinKeep, 1'b0, CondNone,      PhIdle,       PhIdle};
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

@@ rtl/i2c_register_table_writer_unit.sv @@
// top level of the i2c master that replays a table of register writes
// usage:
//   req channel carries one request per cycle at most: tuser is the opcode
//   (append entry, start run, bus timer tick, no operation), tdata carries the
//   register address, the register value and the sampled sda level.
//   every accepted request gives exactly one rsp item with the scl and sda
//   release levels, busy, done, nak abort and the count of written entries.
//   csr_we loads the seven-bit device address; write it only while idle.
//   a request is handled in the cycle it is accepted and its rsp appears on the
//   next cycle from the single output register after the microcode step; one
//   request per cycle is taken while the rsp channel is not stalled.
//   while busy each tick walks one step of the control store (start, 8 bit phases and
//   ack sampling per byte, stop); register and value bytes come from the table ram.
//   the table ram has no reset; only entries below the fill count are shifted out.
//   reset clears the sequencer to idle, empties the table, releases both pins
//   and sets the device address to 0x60.
//   when rsp_tready is low a pending rsp holds and req_tready drops until it drains.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_table_writer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // reg_address [7:0], reg_value [15:8], sda_level [16], zero [23:17]
   input  wire logic [23:0] req_tdata,
   // opcode [1:0]
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // scl_release [0], sda_release [1], busy_res [2], done_res [3],
   // nak_abort [4], entries_written [13:5], zero [15:14]
   output      logic [15:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [i2crtw_pkg::DevAddrWidth-1:0] csr_wdata
);

   import i2crtw_pkg::*;

   `include "i2c_register_table_writer_unit_defines.svh"

   logic                     req_fire;
   op_type                   req_op;
   logic [ByteWidth-1:0]     req_reg_address;
   logic [ByteWidth-1:0]     req_reg_value;
   logic                     req_sda;

   phase_type                phase_ff, phase_in;
   logic [CountWidth-1:0]    entry_count_ff, entry_count_in;
   logic [CountWidth-1:0]    entry_index_ff, entry_index_in;
   logic [BitCountWidth-1:0] bit_count_ff, bit_count_in;
   byte_sel_type             byte_sel_ff, byte_sel_in;
   logic [ByteWidth-1:0]     shift_ff, shift_in;
   logic                     abort_ff, abort_in;
   logic                     done_ff, done_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic [DevAddrWidth-1:0]  dev_addr_ff, dev_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_data_ff, rsp_data_in;

   ucode_type                uc;
   logic                     busy;
   logic                     taken;
   byte_sel_type             load_sel;
   logic [ByteWidth-1:0]     load_byte;
   logic                     ram_we;
   logic [EntryWidth-1:0]    ram_rd_data;

   logic                     index_ok;
   logic                     done_ok;
   logic                     abort_ok;

   assign req_fire        = req_tvalid & req_tready;
   assign req_op          = op_type'(req_tuser);
   assign req_reg_address = req_tdata[7:0];
   assign req_reg_value   = req_tdata[15:8];
   assign req_sda         = req_tdata[16];
   assign req_tready      = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign busy            = (phase_ff != PhIdle);
   assign uc              = ucode_rom(phase_ff);

   i2crtw_ram #(
      .Width (EntryWidth),
      .Depth (TableDepth)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (entry_count_ff[IndexWidth-1:0]),
      .wr_data ({req_reg_address, req_reg_value}),
      .rd_addr (entry_index_ff[IndexWidth-1:0]),
      .rd_data (ram_rd_data)
   );

   // byte to shift out
   always_comb begin
      load_sel = uc.load_first ? ByteDevice : byte_sel_type'(byte_sel_ff + 2'd1);
      case (load_sel)
         ByteDevice:   load_byte = {dev_addr_ff, 1'b0};
         ByteRegister: load_byte = ram_rd_data[EntryWidth-1:ByteWidth];
         default:      load_byte = ram_rd_data[ByteWidth-1:0];
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      entry_count_in = entry_count_ff;
      entry_index_in = entry_index_ff;
      bit_count_in   = bit_count_ff;
      byte_sel_in    = byte_sel_ff;
      shift_in       = shift_ff;
      abort_in       = abort_ff;
      done_in        = done_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      dev_addr_in    = csr_we ? csr_wdata : dev_addr_ff;
      ram_we         = 1'b0;
      taken          = 1'b0;

      if (req_fire) begin
         unique case (req_op)
            OpAppend: begin
               if (!busy && entry_count_ff < CountWidth'(TableDepth)) begin
                  ram_we         = 1'b1;
                  entry_count_in = entry_count_ff + CountWidth'(1);
               end
            end
            OpStart: begin
               if (!busy) begin
                  entry_index_in = '0;
                  abort_in       = 1'b0;
                  bit_count_in   = '0;
                  byte_sel_in    = ByteDevice;
                  scl_in         = 1'b1;
                  sda_in         = 1'b1;
                  if (entry_count_ff == '0) begin
                     done_in = 1'b1;
                  end else begin
                     done_in  = 1'b0;
                     phase_in = PhStartSda;
                  end
               end
            end
            OpTick: begin
               if (busy) begin
                  case (uc.scl_op)
                     PinLow:  scl_in = 1'b0;
                     PinHigh: scl_in = 1'b1;
                     default: scl_in = scl_ff;
                  endcase
                  case (uc.sda_op)
                     PinLow:  sda_in = 1'b0;
                     PinHigh: sda_in = 1'b1;
                     default: sda_in = sda_ff;
                  endcase
                  unique case (uc.cond)
                     CondNone:      taken = 1'b0;
                     CondBitMore:   taken = (bit_count_ff != BitCountWidth'(LastBit));
                     CondAckMore:   taken = !req_sda && (byte_sel_ff != ByteValue);
                     CondEntryMore: taken = !abort_ff && (entry_index_ff < entry_count_ff);
                  endcase
                  phase_in = taken ? uc.jump_step : uc.next_step;
                  if (uc.load_first || (uc.cond == CondAckMore && taken)) begin
                     byte_sel_in  = load_sel;
                     shift_in     = load_byte;
                     bit_count_in = '0;
                     sda_in       = |(load_byte & MsbMask);
                  end
                  if (uc.cond == CondBitMore && taken) begin
                     shift_in     = {shift_ff[ByteWidth-2:0], 1'b0};
                     bit_count_in = bit_count_ff + BitCountWidth'(1);
                     sda_in       = shift_ff[ByteWidth-2];
                  end
                  if (uc.cond == CondAckMore && !taken) begin
                     if (!req_sda) begin
                        entry_index_in = entry_index_ff + CountWidth'(1);
                     end else begin
                        abort_in = 1'b1;
                     end
                  end
                  if (uc.cond == CondEntryMore) begin
                     if (taken) begin
                        scl_in = 1'b1;
                        sda_in = 1'b1;
                     end else begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
            OpNop: begin
               taken = 1'b0;
            end
         endcase
      end

      rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = {2'b00, 9'(entry_index_in), abort_in, done_in,
                      (phase_in != PhIdle), sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhIdle;
         entry_count_ff <= '0;
         entry_index_ff <= '0;
         bit_count_ff   <= '0;
         byte_sel_ff    <= ByteDevice;
         shift_ff       <= '0;
         abort_ff       <= 1'b0;
         done_ff        <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         dev_addr_ff    <= DevAddrReset;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         entry_count_ff <= entry_count_in;
         entry_index_ff <= entry_index_in;
         bit_count_ff   <= bit_count_in;
         byte_sel_ff    <= byte_sel_in;
         shift_ff       <= shift_in;
         abort_ff       <= abort_in;
         done_ff        <= done_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         dev_addr_ff    <= dev_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign index_ok = (entry_index_ff <= entry_count_ff);
   assign done_ok  = !done_ff || (phase_ff == PhIdle);
   assign abort_ok = !abort_ff || (phase_ff == PhIdle) || (phase_ff == PhStopScl) ||
                     (phase_ff == PhStopSda) || (phase_ff == PhStopGap);

   `I2CRTW_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_fire, rsp_tvalid, "request without rsp")
   `I2CRTW_ASSERT_ALWAYS(a_index_in_range, clock, reset, index_ok, "index beyond fill count")
   `I2CRTW_ASSERT_ALWAYS(a_done_only_idle, clock, reset, done_ok, "done while busy")
   `I2CRTW_ASSERT_ALWAYS(a_abort_in_stop, clock, reset, abort_ok, "abort outside stop")

endmodule

`default_nettype wire

@@ rtl/i2crtw_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module i2crtw_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                            wr_data,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output      logic [Width-1:0]                            rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
